/* design/atsar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsar_pkg
// Shared types and constants for the associative tag store with age-based
// replacement.
// ----------------------------------------------------------------------------
package atsar_pkg;

    localparam int DEF_ENTRIES  = 10;
    localparam int DEF_KEY_BITS = 64;
    localparam int DEF_AGE_BITS = 16;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              replaced_used;
    } rsp_t;

endpackage

/* design/atsar_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsar_match
// Parallel key compare against every valid entry; lowest index wins.
// ----------------------------------------------------------------------------
module atsar_match
    import atsar_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int IDX_W    = $clog2(ENTRIES)
)
(
    input  logic [ENTRIES-1:0]  valid,
    input  logic [KEY_BITS-1:0] keys [ENTRIES],
    input  logic [KEY_BITS-1:0] key,
    output logic                hit,
    output logic [IDX_W-1:0]    idx
);

    logic [ENTRIES-1:0] eq;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            eq[i] = valid[i] && (keys[i] == key);
        end
    end

    // priority encode, lowest index first
    always_comb
    begin
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (eq[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign hit = |eq;

endmodule

/* design/atsar_victim.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsar_victim
// Picks the entry an insert writes: first free entry, else the oldest.
// ----------------------------------------------------------------------------
module atsar_victim
    import atsar_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int AGE_BITS = DEF_AGE_BITS,
    parameter int IDX_W    = $clog2(ENTRIES)
)
(
    input  logic [ENTRIES-1:0]  valid,
    input  logic [AGE_BITS-1:0] ages [ENTRIES],
    output logic [IDX_W-1:0]    idx,
    output logic                used
);

    logic [ENTRIES-1:0] is_max;
    logic [ENTRIES-1:0] cand;

    // entry i is the pick if strictly older than all below and no younger
    // than all above it
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            is_max[i] = 1'b1;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (j < i)
                begin
                    if (!(ages[i] > ages[j]))
                    begin
                        is_max[i] = 1'b0;
                    end
                end
                else if (j > i)
                begin
                    if (ages[i] < ages[j])
                    begin
                        is_max[i] = 1'b0;
                    end
                end
            end
        end
    end

    assign used = &valid;
    assign cand = used ? is_max : ~valid;

    always_comb
    begin
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

endmodule

/* design/assoc_tag_store_age_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_tag_store_age_replacement
// Fully associative tag store with a saturating age counter per entry.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): mode selects lookup or
//   insert, key is the tag. Only the low KEY_BITS key bits are kept.
//   Response channel (rsp_valid / rsp_stall / rsp): one response per request,
//   in order: hit flag, slot index and whether an insert evicted a used entry.
//   A request is registered in the request register, its response in the
//   response register. One request is taken every cycle unless the receiver
//   stalls; each passes once through the parallel key compare and the age
//   maximum between the two registers, which also update the entry state.
//   Reset empties every entry and sets all ages to one; a request may be
//   sent in the first cycle after reset.
//   While the receiver stalls, the response register holds and one further
//   request waits in the request register; req_stall then goes high.
// ----------------------------------------------------------------------------
module assoc_tag_store_age_replacement
    import atsar_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int AGE_BITS = DEF_AGE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                in_vld_reg;
    req_t                in_data_reg;
    logic                rsp_vld_reg;
    rsp_t                rsp_data_reg;
    rsp_t                rsp_next;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [AGE_BITS-1:0] age_reg  [ENTRIES];
    logic [AGE_BITS-1:0] age_next [ENTRIES];
    logic [KEY_BITS-1:0] key_reg  [ENTRIES];

    logic                adv;
    logic                proc;
    logic                is_ins;
    logic [KEY_BITS-1:0] key_cut;
    logic                m_hit;
    logic [IDX_W-1:0]    m_idx;
    logic [IDX_W-1:0]    v_idx;
    logic                v_used;
    logic [IDX_W-1:0]    slot_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign adv       = !rsp_vld_reg || !rsp_stall;
    assign proc      = in_vld_reg && adv;
    assign req_stall = in_vld_reg && !adv;
    assign is_ins    = (in_data_reg.mode == MODE_INSERT);
    assign key_cut   = in_data_reg.key[KEY_BITS-1:0];

    atsar_match #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_match (
        .valid (valid_reg),
        .keys  (key_reg),
        .key   (key_cut),
        .hit   (m_hit),
        .idx   (m_idx)
    );

    atsar_victim #(
        .ENTRIES  (ENTRIES),
        .AGE_BITS (AGE_BITS),
        .IDX_W    (IDX_W)
    ) u_victim (
        .valid (valid_reg),
        .ages  (age_reg),
        .idx   (v_idx),
        .used  (v_used)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_data_reg <= req;
        end
    end

    // entry state update
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (proc)
        begin
            if (is_ins)
            begin
                valid_next[v_idx] = 1'b1;
                age_next[v_idx]   = AGE_ONE;
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (m_hit && (m_idx == IDX_W'(i)))
                    begin
                        age_next[i] = AGE_ONE + AGE_ONE;
                    end
                    else if (age_reg[i] != AGE_MAX)
                    begin
                        age_next[i] = age_reg[i] + AGE_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= AGE_ONE;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && is_ins)
        begin
            key_reg[v_idx] <= key_cut;
        end
    end

    // response
    always_comb
    begin
        if (is_ins)
        begin
            slot_idx = v_idx;
        end
        else if (m_hit)
        begin
            slot_idx = m_idx;
        end
        else
        begin
            slot_idx = '0;
        end
        slot_ext               = {{SLOT_W{1'b0}}, slot_idx};
        rsp_next.hit           = !is_ins && m_hit;
        rsp_next.slot          = slot_ext[SLOT_W-1:0];
        rsp_next.replaced_used = is_ins && v_used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_data_reg;

`ifndef SYNTHESIS
    a_ins_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_ins) |=> valid_reg[$past(v_idx)])
        else $error("inserted entry not valid");

    a_free_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_ins && !(&valid_reg)) |=> !rsp_data_reg.replaced_used)
        else $error("eviction reported while a free entry existed");

    a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("valid entry count decreased");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg |-> !(rsp_data_reg.hit && rsp_data_reg.replaced_used))
        else $error("response flags both hit and eviction");
`endif

endmodule
